FILE: rtl/hnt_pkg.sv
// Shared types, constants and helper functions of the held-note tracker.
`default_nettype none

package hnt_pkg;

  // Key space: one bit per (channel, pitch)
  localparam int CHANNELS   = 16;
  localparam int PITCHES    = 128;
  localparam int KEY_COUNT  = CHANNELS * PITCHES;
  localparam int WORD_BITS  = 64;
  localparam int WORD_COUNT = KEY_COUNT / WORD_BITS;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int WADDR_W    = $clog2(WORD_COUNT);

  // Field widths
  localparam int REQ_W   = 3;
  localparam int CH_W    = 4;
  localparam int PITCH_W = 7;
  localparam int KEY_W   = CH_W + PITCH_W;
  localparam int VEL_W   = 7;
  localparam int OFF_W   = 16;
  localparam int COUNT_W = 12;

  // Channel bound for the range check, one bit wider than the channel field
  localparam logic [CH_W:0] CH_LIMIT = (CH_W + 1)'(CHANNELS);

  // Request codes on the input port
  localparam logic [REQ_W-1:0] REQ_NOTE_ON      = 3'd0;
  localparam logic [REQ_W-1:0] REQ_NOTE_OFF     = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CHASE_ON     = 3'd2;
  localparam logic [REQ_W-1:0] REQ_RELEASE_NEXT = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR_ALL    = 3'd4;

  // Event kinds on the result port
  localparam logic EVT_NOTE_OFF = 1'b0;
  localparam logic EVT_NOTE_ON  = 1'b1;

  // Operations that reach the back end
  typedef enum logic [2:0] {
    OP_NOTE_ON,
    OP_NOTE_OFF,
    OP_CHASE_ON,
    OP_RELEASE,
    OP_CLEAR
  } op_t;

  // Classified command passed from front to back
  typedef struct packed {
    op_t                op;
    logic [CH_W-1:0]    channel;
    logic [PITCH_W-1:0] pitch;
    logic [VEL_W-1:0]   velocity;
    logic [OFF_W-1:0]   offset;
  } cmd_t;

  // One result beat
  typedef struct packed {
    logic               is_event;
    logic               event_kind;
    logic [CH_W-1:0]    channel;
    logic [PITCH_W-1:0] pitch;
    logic [VEL_W-1:0]   velocity;
    logic [OFF_W-1:0]   offset;
    logic [COUNT_W-1:0] held_count;
    logic               last;
  } result_t;

  // Index of the lowest set bit of a bitmap word (0 when empty)
  function automatic logic [BIT_W-1:0] low_bit(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  // Index of the lowest non-empty word (0 when all empty)
  function automatic logic [WADDR_W-1:0] low_word(input logic [WORD_COUNT-1:0] nz);
    logic [WADDR_W-1:0] idx;
    idx = '0;
    for (int i = WORD_COUNT - 1; i >= 0; i--) begin
      if (nz[i]) idx = WADDR_W'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/hnt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hnt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/hnt_front.sv
// Front end: accepts requests, classifies them and queues commands for the back end.
`default_nettype none

module hnt_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [hnt_pkg::REQ_W-1:0]   req_type,
  input  wire logic [hnt_pkg::CH_W-1:0]    channel,
  input  wire logic [hnt_pkg::PITCH_W-1:0] pitch,
  input  wire logic [hnt_pkg::VEL_W-1:0]   velocity,
  input  wire logic [hnt_pkg::OFF_W-1:0]   sample_offset,
  output logic                             cmd_valid,
  output hnt_pkg::cmd_t                    cmd,
  input  wire logic                        cmd_pop
);

  hnt_pkg::cmd_t q [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    count;
  hnt_pkg::cmd_t cls;
  logic          keep;
  logic          ch_ok;
  logic          accept;
  logic          enq;
  logic          deq;

  // Classify the incoming beat; unused codes and bad channels on note requests are dropped
  always_comb begin
    ch_ok        = ({1'b0, channel} < hnt_pkg::CH_LIMIT);
    cls.channel  = channel;
    cls.pitch    = pitch;
    cls.velocity = velocity;
    cls.offset   = sample_offset;
    cls.op       = hnt_pkg::OP_CLEAR;
    keep         = 1'b0;
    case (req_type)
      hnt_pkg::REQ_NOTE_ON: begin
        cls.op = hnt_pkg::OP_NOTE_ON;
        keep   = ch_ok;
      end
      hnt_pkg::REQ_NOTE_OFF: begin
        cls.op = hnt_pkg::OP_NOTE_OFF;
        keep   = ch_ok;
      end
      hnt_pkg::REQ_CHASE_ON: begin
        cls.op = hnt_pkg::OP_CHASE_ON;
        keep   = ch_ok;
      end
      hnt_pkg::REQ_RELEASE_NEXT: begin
        cls.op = hnt_pkg::OP_RELEASE;
        keep   = 1'b1;
      end
      hnt_pkg::REQ_CLEAR_ALL: begin
        cls.op = hnt_pkg::OP_CLEAR;
        keep   = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full      = (count == 2'd2);
  assign accept    = push && !full;
  assign enq       = accept && keep;
  assign cmd_valid = (count != 2'd0);
  assign deq       = cmd_pop && cmd_valid;
  assign cmd       = q[rptr];

  // Two-entry command queue: control
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (enq) wptr <= ~wptr;
      if (deq) rptr <= ~rptr;
      if (enq && !deq) begin
        count <= count + 2'd1;
      end else if (deq && !enq) begin
        count <= count - 2'd1;
      end
    end
  end

  // Two-entry command queue: storage
  always_ff @(posedge clk) begin
    if (enq) q[wptr] <= cls;
  end

endmodule

`default_nettype wire

FILE: rtl/hnt_back.sv
// Back end: bitmap read-modify-write, release search and result buffer.
`default_nettype none

module hnt_back (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    cmd_valid,
  input  wire hnt_pkg::cmd_t cmd,
  output logic         cmd_pop,
  output logic         res_valid,
  output hnt_pkg::result_t res,
  input  wire logic    res_pop
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ISSUE = 3'b010,
    S_DATA  = 3'b100
  } state_t;

  state_t                               state;
  hnt_pkg::cmd_t                        cur;
  logic [hnt_pkg::WADDR_W-1:0]          waddr;
  logic                                 rel_found;
  logic [hnt_pkg::WORD_COUNT-1:0]       nz;
  logic [hnt_pkg::COUNT_W-1:0]          total;
  logic [hnt_pkg::COUNT_W-1:0]          total_next;
  hnt_pkg::result_t                     res_q [2];
  logic [1:0]                           rcount;
  logic [1:0]                           n_res;
  logic [hnt_pkg::KEY_W-1:0]            key;
  logic [hnt_pkg::KEY_W-1:0]            rel_key;
  logic [hnt_pkg::WADDR_W-1:0]          rd_addr;
  logic [hnt_pkg::WORD_BITS-1:0]        rdata;
  logic [hnt_pkg::WORD_BITS-1:0]        word;
  logic [hnt_pkg::WORD_BITS-1:0]        mask;
  logic [hnt_pkg::WORD_BITS-1:0]        new_word;
  logic [hnt_pkg::BIT_W-1:0]            bit_sel;
  logic                                 held;
  logic                                 wr_word;
  logic                                 ram_we;
  logic                                 ram_re;
  hnt_pkg::result_t                     r0;
  hnt_pkg::result_t                     r1;

  // Start a new command only with an empty result buffer
  assign cmd_pop   = (state == S_IDLE) && cmd_valid && (rcount == 2'd0);
  assign res_valid = (rcount != 2'd0);
  assign res       = res_q[0];

  // Read address: lowest non-empty word for release, else the key's word
  assign key = {cur.channel, cur.pitch};
  always_comb begin
    if (cur.op == hnt_pkg::OP_RELEASE) begin
      rd_addr = hnt_pkg::low_word(nz);
    end else begin
      rd_addr = hnt_pkg::WADDR_W'(key >> hnt_pkg::BIT_W);
    end
  end

  assign ram_re = (state == S_ISSUE);
  assign ram_we = (state == S_DATA) && wr_word;

  hnt_ram #(
    .WIDTH (hnt_pkg::WORD_BITS),
    .DEPTH (hnt_pkg::WORD_COUNT)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (new_word),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // Words whose summary flag is clear read as empty
  assign word    = rdata & {hnt_pkg::WORD_BITS{nz[waddr]}};
  assign bit_sel = (cur.op == hnt_pkg::OP_RELEASE) ? hnt_pkg::low_bit(word)
                                                   : key[hnt_pkg::BIT_W-1:0];
  assign held    = word[bit_sel];
  assign mask    = {{(hnt_pkg::WORD_BITS - 1){1'b0}}, 1'b1} << bit_sel;
  assign rel_key = hnt_pkg::KEY_W'({waddr, bit_sel});

  // Update of the word and the count, and the results it causes
  always_comb begin
    new_word   = word;
    wr_word    = 1'b0;
    total_next = total;
    n_res      = 2'd0;
    r0         = '0;
    r1         = '0;
    r0.is_event = 1'b1;
    r0.channel  = cur.channel;
    r0.pitch    = cur.pitch;
    r0.offset   = cur.offset;
    r0.last     = 1'b1;
    r1          = r0;
    case (cur.op)
      hnt_pkg::OP_NOTE_ON: begin
        if (held) begin
          // re-attack: note-off first, then the note-on
          r0.event_kind = hnt_pkg::EVT_NOTE_OFF;
          r0.last       = 1'b0;
          r1.event_kind = hnt_pkg::EVT_NOTE_ON;
          r1.velocity   = cur.velocity;
          n_res         = 2'd2;
        end else begin
          new_word      = word | mask;
          wr_word       = 1'b1;
          total_next    = total + hnt_pkg::COUNT_W'(1);
          r0.event_kind = hnt_pkg::EVT_NOTE_ON;
          r0.velocity   = cur.velocity;
          n_res         = 2'd1;
        end
      end
      hnt_pkg::OP_NOTE_OFF: begin
        if (held) begin
          new_word      = word & ~mask;
          wr_word       = 1'b1;
          total_next    = total - hnt_pkg::COUNT_W'(1);
          r0.event_kind = hnt_pkg::EVT_NOTE_OFF;
          n_res         = 2'd1;
        end
      end
      hnt_pkg::OP_CHASE_ON: begin
        if (!held) begin
          new_word      = word | mask;
          wr_word       = 1'b1;
          total_next    = total + hnt_pkg::COUNT_W'(1);
          r0.event_kind = hnt_pkg::EVT_NOTE_ON;
          r0.velocity   = cur.velocity;
          n_res         = 2'd1;
        end
      end
      hnt_pkg::OP_RELEASE: begin
        n_res = 2'd1;
        if (rel_found) begin
          new_word      = word & ~mask;
          wr_word       = 1'b1;
          total_next    = total - hnt_pkg::COUNT_W'(1);
          r0.event_kind = hnt_pkg::EVT_NOTE_OFF;
          r0.channel    = hnt_pkg::CH_W'(rel_key >> hnt_pkg::PITCH_W);
          r0.pitch      = rel_key[hnt_pkg::PITCH_W-1:0];
        end else begin
          // nothing held: empty marker beat
          r0          = '0;
          r0.last     = 1'b1;
        end
      end
      default: begin
        n_res = 2'd0;
      end
    endcase
    r0.held_count = total_next;
    r1.held_count = total_next;
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      nz     <= '0;
      total  <= '0;
      rcount <= 2'd0;
    end else begin
      if (res_pop && rcount != 2'd0) rcount <= rcount - 2'd1;
      case (state)
        S_IDLE: begin
          if (cmd_pop) state <= S_ISSUE;
        end
        S_ISSUE: begin
          if (cur.op == hnt_pkg::OP_CLEAR) begin
            nz    <= '0;
            total <= '0;
            state <= S_IDLE;
          end else begin
            state <= S_DATA;
          end
        end
        S_DATA: begin
          if (wr_word) nz[waddr] <= |new_word;
          total  <= total_next;
          rcount <= n_res;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Command, address and result payload
  always_ff @(posedge clk) begin
    if (cmd_pop) cur <= cmd;
    if (state == S_ISSUE) begin
      waddr     <= rd_addr;
      rel_found <= |nz;
    end
    if (state == S_DATA) begin
      res_q[0] <= r0;
      res_q[1] <= r1;
    end else if (res_pop && rcount != 2'd0) begin
      res_q[0] <= res_q[1];
    end
  end

`ifndef SYNTHESIS
  a_empty_map_zero_count: assert property (@(posedge clk) disable iff (rst)
    (nz == '0) |-> (total == '0))
    else $error("held count nonzero with an empty bitmap");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (total <= hnt_pkg::COUNT_W'(hnt_pkg::KEY_COUNT)))
    else $error("held count above key count");

  a_results_into_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_DATA) |-> (rcount == 2'd0))
    else $error("results written over waiting beats");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (state == S_ISSUE && cur.op == hnt_pkg::OP_CLEAR) |=> (total == '0 && nz == '0))
    else $error("clear-all left held notes");
`endif

endmodule

`default_nettype wire

FILE: rtl/held_note_tracker.sv
// Path: a request passes the front queue, then the back end's issue and data states,
//   and is then written into the result buffer before its first result shows.
// Order: the back end takes one request at a time, only while idle with an empty
//   result buffer; all but clear-all do a RAM read-modify-write of one 64-bit word.
// Reset: clears both queues, the held count and the per-word summary flags; the bitmap
//   RAM itself is not swept, a word whose flag is clear reads as empty.
`default_nettype none

module held_note_tracker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [hnt_pkg::REQ_W-1:0]   req_type,
  input  wire logic [hnt_pkg::CH_W-1:0]    channel,
  input  wire logic [hnt_pkg::PITCH_W-1:0] pitch,
  input  wire logic [hnt_pkg::VEL_W-1:0]   velocity,
  input  wire logic [hnt_pkg::OFF_W-1:0]   sample_offset,
  output logic                             empty,
  input  wire logic                        pop,
  output logic                             is_event,
  output logic                             event_kind,
  output logic [hnt_pkg::CH_W-1:0]         out_channel,
  output logic [hnt_pkg::PITCH_W-1:0]      out_pitch,
  output logic [hnt_pkg::VEL_W-1:0]        out_velocity,
  output logic [hnt_pkg::OFF_W-1:0]        out_offset,
  output logic [hnt_pkg::COUNT_W-1:0]      held_count,
  output logic                             last
);

  hnt_pkg::cmd_t    cmd;
  logic             cmd_valid;
  logic             cmd_pop;
  logic             res_valid;
  hnt_pkg::result_t res;

  hnt_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .req_type      (req_type),
    .channel       (channel),
    .pitch         (pitch),
    .velocity      (velocity),
    .sample_offset (sample_offset),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  hnt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (pop)
  );

  // Result ports
  assign empty        = !res_valid;
  assign is_event     = res.is_event;
  assign event_kind   = res.event_kind;
  assign out_channel  = res.channel;
  assign out_pitch    = res.pitch;
  assign out_velocity = res.velocity;
  assign out_offset   = res.offset;
  assign held_count   = res.held_count;
  assign last         = res.last;

endmodule

`default_nettype wire
